// ===== hdl/tblr_pkg.sv =====
`timescale 1ns / 1ps

package tblr_pkg;

    // fixed geometry of the video memory and the background map
    localparam int VRAM_BYTES    = 8192;
    localparam int VRAM_AW       = 13;
    localparam int TILES_PER_ROW = 32;
    localparam int COL_W         = 5;
    localparam int LINE_W        = 8;

    localparam int VISIBLE_LINES_DEF = 144;
    localparam int TOTAL_LINES_DEF   = 154;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [VRAM_AW-1:0] MAP_BASE_LOW     = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP_BASE_HIGH    = 13'h1C00;
    localparam logic [VRAM_AW-1:0] SIGNED_TILE_BASE = 13'h1000;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(TILES_PER_ROW - 1);

    // input item codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_DISPLAY_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_MAP_SELECT       = 2'd1;
    localparam logic [1:0] CFG_TILE_DATA_SELECT = 2'd2;
    localparam logic [1:0] CFG_SHADE_PALETTE    = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [VRAM_AW-1:0] vram_offset;
        logic [7:0]         write_byte;
    } in_item_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  tile_column;
        logic [15:0]       pixel_shades;
        logic              last_group;
    } out_item_t;

    typedef struct packed {
        logic       display_enable;
        logic       map_select;
        logic       tile_data_select;
        logic [7:0] shade_palette;
    } cfg_t;

    // command passed from the front end to the render engine
    typedef struct packed {
        logic               is_render;
        logic [VRAM_AW-1:0] offset;
        logic [7:0]         data;
        logic [LINE_W-1:0]  line;
    } cmd_t;

endpackage

// ===== hdl/tblr_front.sv =====
`timescale 1ns / 1ps

module tblr_front
    import tblr_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES   = TOTAL_LINES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     display_enable,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              accept;
    logic              is_tick;
    logic              visible;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_tick  = (in_data.mode == MODE_TICK);
    assign visible  = (line_reg < LINE_W'(VISIBLE_LINES));

    // writes always go through the queue so they stay ordered with renders
    assign push = accept && (!is_tick || (display_enable && visible));

    always_comb
    begin
        push_cmd.is_render = is_tick;
        push_cmd.offset    = in_data.vram_offset;
        push_cmd.data      = in_data.write_byte;
        push_cmd.line      = line_reg;
    end

    always_comb
    begin
        line_next = line_reg;
        if (accept && is_tick && display_enable)
        begin
            if (line_reg == LINE_W'(TOTAL_LINES - 1))
                line_next = '0;
            else
                line_next = line_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_reg <= '0;
        else
            line_reg <= line_next;
    end

endmodule

// ===== hdl/tblr_queue.sv =====
`timescale 1ns / 1ps

module tblr_queue
    import tblr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hdl/tblr_back.sv =====
`timescale 1ns / 1ps

module tblr_back
    import tblr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      head,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAP   = 5'b00010,
        ST_LO    = 5'b00100,
        ST_HI    = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    logic [7:0] vram [VRAM_BYTES];

    state_t             state_reg;
    state_t             state_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  line_next;
    logic [VRAM_AW-1:0] addr_reg;
    logic [VRAM_AW-1:0] addr_next;
    logic [7:0]         lo_reg;
    logic [7:0]         lo_next;
    logic               pend_reg;
    logic               pend_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;
    logic [7:0]         rd_data_reg;

    logic               mem_we;
    logic               mem_re;
    logic [VRAM_AW-1:0] mem_ra;
    logic               slot_free;
    logic               emit;
    logic [COL_W-1:0]   emit_col;
    logic [15:0]        shades;
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] tile_addr;
    logic [VRAM_AW-1:0] tile_base;
    logic [1:0]         color;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign map_addr = (cfg.map_select ? MAP_BASE_HIGH : MAP_BASE_LOW)
                      + VRAM_AW'({line_reg[LINE_W-1:3], {COL_W{1'b0}}})
                      + VRAM_AW'(col_reg);

    // signed tiles sit around the signed base, unsigned ones from offset zero
    assign tile_base = cfg.tile_data_select
                       ? {1'b0, rd_data_reg, 4'b0000}
                       : SIGNED_TILE_BASE + {rd_data_reg[7], rd_data_reg, 4'b0000};
    assign tile_addr = tile_base + VRAM_AW'({line_reg[2:0], 1'b0});

    // hi byte sits in the read register, lo byte was kept from the read before it
    always_comb
    begin
        shades = '0;
        color  = '0;
        for (int p = 0; p < 8; p++)
        begin
            color = {rd_data_reg[7-p], lo_reg[7-p]};
            shades[2*p +: 2] = cfg.shade_palette[2*color +: 2];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        addr_next      = addr_reg;
        lo_next        = lo_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_ra         = map_addr;
        emit           = 1'b0;
        emit_col       = col_reg - 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.is_render)
                    begin
                        line_next  = head.line;
                        col_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_MAP;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_MAP:
            begin
                if (!pend_reg || slot_free)
                begin
                    emit       = pend_reg;
                    pend_next  = 1'b0;
                    mem_re     = 1'b1;
                    mem_ra     = map_addr;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                mem_re     = 1'b1;
                mem_ra     = tile_addr;
                addr_next  = tile_addr;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                lo_next   = rd_data_reg;
                mem_re    = 1'b1;
                mem_ra    = addr_reg + 1'b1;
                pend_next = 1'b1;
                if (col_reg == LAST_COL)
                    state_next = ST_DRAIN;
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_DRAIN:
            begin
                emit_col = col_reg;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.line_number  = line_reg;
            out_data_next.tile_column  = emit_col;
            out_data_next.pixel_shades = shades;
            out_data_next.last_group   = (emit_col == LAST_COL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg     <= line_next;
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        out_data_reg <= out_data_next;
    end

    // single port video memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vram[head.offset] <= head.data;
        if (mem_re)
            rd_data_reg <= vram[mem_ra];
    end

endmodule

// ===== hdl/tile_background_line_renderer_top.sv =====
`timescale 1ns / 1ps

// tile background line renderer
// input channel (in_valid / in_stall / in_data): mode 0 stores write_byte at
//   vram_offset, mode 1 is a scanline tick; a transfer happens when in_valid
//   is high and in_stall is low
// output channel (out_valid / out_stall / out_data): a rendered tick gives 32
//   transfers, tile columns 0..31 in order, last_group set on column 31
// config port: cfg_we writes cfg_wdata into register cfg_index at the clock
//   edge (0 display enable, 1 map select, 2 tile data select, 3 palette)
// the front end classifies items and steps the line counter, a small command
//   queue decouples it from the render engine that owns the video memory
// a write is done in the engine's idle state; a rendered line reads the map,
//   low and high bytes of each tile column in turn on the single memory
//   port, each column's group going out while the next column is read; the
//   engine takes a new command only once the line's last group is in the output register
// ticks with display off, or on lines past the visible range, give no output
// when the receiver stalls, the output register holds and the engine waits;
//   the input stalls once the command queue fills
// reset clears the line counter, config registers, queue and engine; the
//   video memory holds no reset value

module tile_background_line_renderer_top
    import tblr_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES   = TOTAL_LINES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // configuration registers, to be written only while the block is idle; the block itself does not enforce this
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE:   cfg_next.display_enable   = cfg_wdata[0];
                CFG_MAP_SELECT:       cfg_next.map_select       = cfg_wdata[0];
                CFG_TILE_DATA_SELECT: cfg_next.tile_data_select = cfg_wdata[0];
                CFG_SHADE_PALETTE:    cfg_next.shade_palette    = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // front end: accepts, drops idle ticks, advances the line counter
    tblr_front #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .display_enable (cfg_reg.display_enable),
        .q_full         (q_full),
        .push           (q_push),
        .push_cmd       (push_cmd)
    );

    // command queue keeps writes and renders in arrival order
    tblr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    // render engine with the video memory and the output register
    tblr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head_cmd),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/tblr_checker.sv =====
`timescale 1ns / 1ps

module tblr_checker
    import tblr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    logic [COL_W-1:0] exp_col_reg;

    // column expected on the next output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_col_reg <= '0;
        else if (out_valid && !out_stall)
            exp_col_reg <= out_data.tile_column + 1'b1;
    end

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // columns come out in order and each line starts at column zero
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.tile_column == exp_col_reg)
        else $error("tile column out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_group == (out_data.tile_column == LAST_COL))
        else $error("last group flag mismatch");

    a_line_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.line_number < LINE_W'(VISIBLE_LINES_DEF))
        else $error("line number outside visible range");

endmodule

bind tile_background_line_renderer_top tblr_checker u_tblr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/sv/tb_tile_background_line_renderer_top.sv =====
`timescale 1ns / 1ps

module tb_tile_background_line_renderer_top;
    import tblr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 180;
    localparam int PHASE_ITEMS   = 30;
    // writes may still sit in the queue once every owed group is in, so this
    // covers anything still sitting in the queue
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 5000;

    // shadow of the renderer: video memory, line counter and registers,
    // plus the pixel groups still owed by the block
    class pixel_group_board;
        localparam int REPORT_LIMIT = 10;
        localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(TOTAL_LINES_DEF - 1);

        logic [7:0]        vram_copy [VRAM_BYTES];
        logic [LINE_W-1:0] line_count;
        cfg_t              regs;
        out_item_t         expected_groups [$];
        int                mismatches;
        int                groups_checked;
        int                lines_rendered;
        int                wraps;
        int                transfers;

        function new();
            line_count     = '0;
            regs           = '0;
            mismatches     = 0;
            groups_checked = 0;
            lines_rendered = 0;
            wraps          = 0;
            transfers      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_DISPLAY_ENABLE:   regs.display_enable   = val[0];
                CFG_MAP_SELECT:       regs.map_select       = val[0];
                CFG_TILE_DATA_SELECT: regs.tile_data_select = val[0];
                CFG_SHADE_PALETTE:    regs.shade_palette    = val;
                default: ;
            endcase
        endfunction

        // the 32 pixel groups of one background line
        function void render_line(logic [LINE_W-1:0] ln);
            logic [VRAM_AW-1:0] map_base;
            logic [VRAM_AW-1:0] lo_addr;
            logic [VRAM_AW-1:0] hi_addr;
            logic [7:0]         tile;
            logic [7:0]         lo;
            logic [7:0]         hi;
            logic [1:0]         color;
            out_item_t          grp;
            map_base = regs.map_select ? MAP_BASE_HIGH : MAP_BASE_LOW;
            for (int col = 0; col < TILES_PER_ROW; col++) begin
                // map row is line / 8, 32 entries per row
                tile = vram_copy[map_base + {3'b000, ln[7:3], 5'(col)}];
                if (regs.tile_data_select)
                    lo_addr = {1'b0, tile, 4'b0000};
                else
                    lo_addr = SIGNED_TILE_BASE + {tile[7], tile, 4'b0000};
                // two bytes per tile row
                lo_addr = lo_addr + {9'd0, ln[2:0], 1'b0};
                hi_addr = lo_addr + 13'd1;
                lo = vram_copy[lo_addr];
                hi = vram_copy[hi_addr];
                grp.line_number = ln;
                grp.tile_column = COL_W'(col);
                grp.last_group  = (COL_W'(col) == LAST_COL);
                // leftmost pixel is bit 7 of the row bytes
                for (int p = 0; p < 8; p++) begin
                    color = {hi[7-p], lo[7-p]};
                    grp.pixel_shades[2*p +: 2] = regs.shade_palette[{color, 1'b0} +: 2];
                end
                expected_groups.push_back(grp);
            end
        endfunction

        function void take_item(in_item_t it);
            transfers++;
            if (it.mode == MODE_WRITE)
                vram_copy[it.vram_offset] = it.write_byte;
            else if (regs.display_enable) begin
                if (line_count < VISIBLE_LINES_DEF) begin
                    render_line(line_count);
                    lines_rendered++;
                end
                // invisible lines still step the counter
                if (line_count == LAST_LINE) begin
                    line_count = '0;
                    wraps++;
                end else
                    line_count++;
            end
        endfunction

        function void check_group(out_item_t got);
            out_item_t want;
            if (expected_groups.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel group: line %0d col %0d shades %h last %b",
                             got.line_number, got.tile_column, got.pixel_shades,
                             got.last_group);
                return;
            end
            want = expected_groups.pop_front();
            groups_checked++;
            if (got.line_number !== want.line_number || got.tile_column !== want.tile_column ||
                got.pixel_shades !== want.pixel_shades || got.last_group !== want.last_group)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"pixel group mismatch: expected line %0d col %0d shades %h ",
                              "last %b, got line %0d col %0d shades %h last %b"},
                             want.line_number, want.tile_column, want.pixel_shades,
                             want.last_group, got.line_number, got.tile_column,
                             got.pixel_shades, got.last_group);
            end
        endfunction

        function int close_out();
            if (expected_groups.size() != 0) begin
                mismatches++;
                $display("%0d pixel groups expected but never delivered",
                         expected_groups.size());
            end
            return mismatches;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;

    pixel_group_board board;
    bit               idle_on;
    int               rx_hold;
    int               quiet_cycles = 0;
    int               random_items;

    tile_background_line_renderer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // output side: every transfer is checked against the oldest pending group,
    // then, while gaps are on, stall is held for a random number of cycles
    initial
    begin
        out_stall = 1'b0;
        rx_hold   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                board.check_group(out_data);
                rx_hold = idle_on ? $urandom_range(0, 3) : 0;
            end
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold   = rx_hold - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: any transfer or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one input transfer; valid stays high afterwards so back-to-back items
    // never see valid dropped and raised in the same step
    task automatic send_item(input in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.take_item(it);
    endtask

    // drop valid, let every owed group arrive, then let the queue run dry
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_groups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // all four registers, only ever called with the block idle
    task automatic apply_setting(input cfg_t s);
        write_reg(CFG_DISPLAY_ENABLE, {7'd0, s.display_enable});
        write_reg(CFG_MAP_SELECT, {7'd0, s.map_select});
        write_reg(CFG_TILE_DATA_SELECT, {7'd0, s.tile_data_select});
        write_reg(CFG_SHADE_PALETTE, s.shade_palette);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t vram_write(logic [VRAM_AW-1:0] off, logic [7:0] b);
        in_item_t it;
        it.mode        = MODE_WRITE;
        it.vram_offset = off;
        it.write_byte  = b;
        return it;
    endfunction

    // offset and byte are don't-care on a tick, so they get random bits
    function automatic in_item_t line_tick();
        in_item_t it;
        it.mode        = MODE_TICK;
        it.vram_offset = VRAM_AW'($urandom);
        it.write_byte  = 8'($urandom);
        return it;
    endfunction

    // mostly ticks; half of the writes land in the two background maps
    function automatic in_item_t random_item();
        in_item_t it;
        if ($urandom_range(0, 3) != 0)
            it = line_tick();
        else if ($urandom_range(0, 1) != 0)
            it = vram_write(MAP_BASE_LOW + VRAM_AW'($urandom_range(0, 2047)), 8'($urandom));
        else
            it = vram_write(VRAM_AW'($urandom), 8'($urandom));
        return it;
    endfunction

    initial
    begin
        cfg_t     s;
        in_item_t it;
        int       phase;

        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DISPLAY_ENABLE;
        cfg_wdata    = '0;
        idle_on      = 1'b0;
        random_items = 0;
        phase        = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // video memory has no reset value: fill all of it before any line renders
        for (int a = 0; a < VRAM_BYTES; a++)
            send_item(vram_write(VRAM_AW'(a), 8'($urandom)));
        wait_drained();

        // unsigned tiles, low map, straight palette: lines 0 and 1
        idle_on = 1'b1;
        s = '{display_enable: 1'b1, map_select: 1'b0, tile_data_select: 1'b1,
              shade_palette: 8'hE4};
        apply_setting(s);
        send_item(vram_write(MAP_BASE_LOW, 8'h00));
        send_item(vram_write(13'h0000, 8'hFF));
        send_item(vram_write(13'h0001, 8'h00));
        // tile 255 sits at the top of the unsigned area
        send_item(vram_write(MAP_BASE_LOW + 13'd1, 8'hFF));
        send_item(vram_write(13'h0FF0, 8'h0F));
        send_item(vram_write(13'h0FF1, 8'h33));
        send_item(vram_write(13'h1FFF, 8'hFF));
        send_item(line_tick());
        send_item(line_tick());
        wait_drained();

        // signed tiles, high map, reversed palette: lines 2 and 3
        s = '{display_enable: 1'b1, map_select: 1'b1, tile_data_select: 1'b0,
              shade_palette: 8'h1B};
        apply_setting(s);
        // tile -128 is the lowest signed tile, row 2
        send_item(vram_write(MAP_BASE_HIGH, 8'h80));
        send_item(vram_write(13'h0804, 8'hAA));
        send_item(vram_write(13'h0805, 8'h55));
        // tile 127 is the highest signed tile
        send_item(vram_write(MAP_BASE_HIGH + 13'd1, 8'h7F));
        send_item(vram_write(13'h17F4, 8'h00));
        send_item(vram_write(13'h17F5, 8'hFF));
        send_item(vram_write(MAP_BASE_HIGH + 13'd2, 8'h00));
        send_item(vram_write(13'h0000, 8'h00));
        send_item(line_tick());
        send_item(line_tick());
        wait_drained();

        // random phases; keep going until the line counter has wrapped, which
        // also walks through the invisible lines
        while (random_items < RANDOM_ITEMS || board.wraps == 0)
        begin
            case (phase)
                // display off: ticks do nothing at all
                0: s = '{display_enable: 1'b0, map_select: 1'b1, tile_data_select: 1'b0,
                         shade_palette: 8'hFF};
                1: s = '{display_enable: 1'b1, map_select: 1'b0, tile_data_select: 1'b0,
                         shade_palette: 8'h00};
                2: s = '{display_enable: 1'b1, map_select: 1'b1, tile_data_select: 1'b1,
                         shade_palette: 8'hFF};
                default:
                begin
                    s.display_enable   = ($urandom_range(0, 7) != 0);
                    s.map_select       = 1'($urandom);
                    s.tile_data_select = 1'($urandom);
                    s.shade_palette    = 8'($urandom);
                end
            endcase
            // every fourth phase runs with no gaps on either side
            idle_on = (phase % 4) != 3;
            apply_setting(s);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = random_item();
                if (!(it.mode == MODE_TICK && !s.display_enable))
                    random_items++;
                send_item(it);
            end
            wait_drained();
            phase++;
        end

        $display("run covered %0d input transfers and %0d pixel groups over %0d rendered lines",
                 board.transfers, board.groups_checked, board.lines_rendered);
        $display("line counter wrapped %0d times across %0d register settings",
                 board.wraps, phase + 2);
        if (board.close_out() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
